// File: sv/ldpc_pkg.sv
// Package for the local DAG path counting unit.
// Holds the request and result structs, the shared count width and the register map.
// No dependencies.
package ldpc_pkg;

  localparam int MAX_NODES_DEF = 256;
  localparam int MAX_EDGES_DEF = 4096;

  localparam int COUNT_W = 64;
  localparam int CLIQUE_W = 5;
  localparam logic [CLIQUE_W-1:0] CLIQUE_RESET = 5'd6;

  // Register map, in units of 32-bit words.
  localparam logic REG_CLIQUE_SIZE = 1'b0;

  typedef struct packed {
    logic [8:0] node_count;
    logic [7:0] from_node;
    logic [7:0] to_node;
    logic       has_edge;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [63:0] path_count;
    logic        overflow;
  } out_t;

endpackage

// File: sv/local_dag_path_count_unit.sv
// Top level of the local DAG path counting unit.
// Depends on ldpc_pkg and ldpc_cnt_ram.
//
// Usage: edges of one local graph arrive as requests on the in_ channel (valid/stall),
// one per cycle, and are written into an edge memory. The request marked last starts the
// count: every node gets a count of one, then clique_size minus two rounds follow, each
// summing the successors' counts, and finally all counts are summed. One result request
// leaves on the out_ channel for each last request; other requests give no result.
// While counting, in_stall is high. The count runs on one shared 64-bit adder with two
// ping-pong count banks. Each round reads every stored edge in turn; an edge with both
// ends below the node count also reads one count from each bank, through the single
// read port of each count bank, and writes their sum back as the tail node's count.
// A finished result sits in an output register; edges of the next graph are accepted
// while it waits, but the next count cannot finish until the result is taken.
// Reset (synchronous, active low) empties the edge memory, clears the overflow flag,
// sets clique_size to 6 and drops any pending result. No clearing pass is needed.
// clique_size is written through the APB port at byte address 0. The user must write
// it only while the unit is idle; the unit itself does not enforce this.
module local_dag_path_count_unit #(
  parameter int MAX_NODES = ldpc_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = ldpc_pkg::MAX_EDGES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ldpc_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output ldpc_pkg::out_t  out_data,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int CDEPTH = (MAX_NODES < 256) ? MAX_NODES : 256;
  localparam int CIW = $clog2(CDEPTH);
  localparam int EAW = $clog2(MAX_EDGES);
  localparam int ETW = $clog2(MAX_EDGES + 1);
  localparam logic [31:0] MAXN32 = MAX_NODES;
  localparam int CW = ldpc_pkg::COUNT_W;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_INIT    = 9'b000000010,
    ST_RCHK    = 9'b000000100,
    ST_CLEAR   = 9'b000001000,
    ST_EADDR   = 9'b000010000,
    ST_EREAD   = 9'b000100000,
    ST_EACC    = 9'b001000000,
    ST_SUMRD   = 9'b010000000,
    ST_SUMACC  = 9'b100000000
  } state_t;

  state_t                        state_r, state_nxt;
  logic                          done_r, done_nxt;
  logic [8:0]                    nodes_r, nodes_nxt;
  logic [8:0]                    idx_r, idx_nxt;
  logic [ETW-1:0]                eidx_r, eidx_nxt;
  logic [ETW-1:0]                edge_total_r, edge_total_nxt;
  logic                          dropped_r, dropped_nxt;
  logic [ldpc_pkg::CLIQUE_W-1:0] round_r, round_nxt;
  logic                          src_r, src_nxt;
  logic [CIW-1:0]                tail_r, tail_nxt;
  logic [CW-1:0]                 acc_r, acc_nxt;
  logic [ldpc_pkg::CLIQUE_W-1:0] clique_r;
  logic                          out_valid_r;
  ldpc_pkg::out_t                out_data_r;

  logic [15:0]                   edge_mem [MAX_EDGES];
  logic [15:0]                   edge_q;

  logic                          in_acc;
  logic [8:0]                    nodes_in;
  logic                          edge_ok;
  logic                          store_full;
  logic [ldpc_pkg::CLIQUE_W-1:0] rounds;
  logic [8:0]                    e_tail, e_head;
  logic                          e_in_range;
  logic                          out_free;
  logic [CW-1:0]                 sum;

  logic [1:0]                    bank_we;
  logic [CIW-1:0]                bank_waddr [2];
  logic [CIW-1:0]                bank_raddr [2];
  logic [CW-1:0]                 bank_rdata [2];
  logic [CW-1:0]                 wr_data;
  logic [CIW-1:0]                src_raddr, dst_addr, wr_addr;
  logic                          wr_src, wr_dst;
  logic [CW-1:0]                 src_rdata, dst_rdata;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc = in_valid && !in_stall;

  assign nodes_in = ({23'd0, in_data.node_count} > MAXN32) ? MAXN32[8:0]
                                                           : in_data.node_count;
  assign edge_ok = in_data.has_edge && ({1'b0, in_data.from_node} < nodes_in)
                   && ({1'b0, in_data.to_node} < nodes_in);
  assign store_full = (edge_total_r == ETW'(MAX_EDGES));
  assign rounds = (clique_r < 5'd2) ? '0 : clique_r - 5'd2;

  assign e_tail = {1'b0, edge_q[15:8]};
  assign e_head = {1'b0, edge_q[7:0]};
  assign e_in_range = (e_tail < nodes_r) && (e_head < nodes_r);
  assign out_free = !out_valid_r || !out_stall;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ldpc_pkg::REG_CLIQUE_SIZE) ? {27'd0, clique_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clique_r <= ldpc_pkg::CLIQUE_RESET;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == ldpc_pkg::REG_CLIQUE_SIZE)) begin
      clique_r <= pwdata[ldpc_pkg::CLIQUE_W-1:0];
    end
  end

  // Edge memory: tail in the upper byte, head in the lower byte.
  always_ff @(posedge clk) begin
    if (in_acc && edge_ok && !store_full) begin
      edge_mem[edge_total_r[EAW-1:0]] <= {in_data.from_node, in_data.to_node};
    end
    edge_q <= edge_mem[eidx_r[EAW-1:0]];
  end

  // Count banks: src_r selects the bank holding the previous round's counts.
  assign src_rdata = src_r ? bank_rdata[1] : bank_rdata[0];
  assign dst_rdata = src_r ? bank_rdata[0] : bank_rdata[1];
  assign src_raddr = (state_r == ST_SUMRD) ? idx_r[CIW-1:0] : e_head[CIW-1:0];
  assign dst_addr  = e_tail[CIW-1:0];

  // The single shared adder serves edge accumulation and the final sum.
  assign sum = ((state_r == ST_EACC) ? dst_rdata : acc_r) + src_rdata;

  always_comb begin
    wr_src = 1'b0;
    wr_dst = 1'b0;
    wr_addr = idx_r[CIW-1:0];
    wr_data = '0;
    case (state_r)
      ST_INIT: begin
        wr_src = (idx_r != nodes_r);
        wr_data = CW'(1);
      end
      ST_CLEAR: begin
        wr_dst = (idx_r != nodes_r);
      end
      ST_EACC: begin
        wr_dst = 1'b1;
        wr_addr = tail_r;
        wr_data = sum;
      end
      default: begin
        wr_src = 1'b0;
      end
    endcase
  end

  always_comb begin
    bank_we[0] = src_r ? wr_dst : wr_src;
    bank_we[1] = src_r ? wr_src : wr_dst;
    bank_waddr[0] = wr_addr;
    bank_waddr[1] = wr_addr;
    bank_raddr[0] = src_r ? dst_addr : src_raddr;
    bank_raddr[1] = src_r ? src_raddr : dst_addr;
  end

  for (genvar b = 0; b < 2; b++) begin : g_bank
    ldpc_cnt_ram #(
      .DEPTH (CDEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (bank_we[b]),
      .waddr (bank_waddr[b]),
      .wdata (wr_data),
      .raddr (bank_raddr[b]),
      .rdata (bank_rdata[b])
    );
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    done_nxt = done_r;
    nodes_nxt = nodes_r;
    idx_nxt = idx_r;
    eidx_nxt = eidx_r;
    edge_total_nxt = edge_total_r;
    dropped_nxt = dropped_r;
    round_nxt = round_r;
    src_nxt = src_r;
    tail_nxt = tail_r;
    acc_nxt = acc_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (edge_ok) begin
            if (store_full) begin
              dropped_nxt = 1'b1;
            end else begin
              edge_total_nxt = edge_total_r + 1'b1;
            end
          end
          if (in_data.last) begin
            nodes_nxt = nodes_in;
            idx_nxt = '0;
            round_nxt = '0;
            src_nxt = 1'b0;
            state_nxt = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        if (idx_r == nodes_r) begin
          state_nxt = ST_RCHK;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_RCHK: begin
        idx_nxt = '0;
        if (round_r == rounds) begin
          acc_nxt = '0;
          state_nxt = ST_SUMRD;
        end else begin
          state_nxt = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (idx_r == nodes_r) begin
          eidx_nxt = '0;
          state_nxt = ST_EADDR;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_EADDR: begin
        if (eidx_r == edge_total_r) begin
          round_nxt = round_r + 1'b1;
          src_nxt = !src_r;
          state_nxt = ST_RCHK;
        end else begin
          state_nxt = ST_EREAD;
        end
      end
      ST_EREAD: begin
        if (e_in_range) begin
          tail_nxt = e_tail[CIW-1:0];
          state_nxt = ST_EACC;
        end else begin
          eidx_nxt = eidx_r + 1'b1;
          state_nxt = ST_EADDR;
        end
      end
      ST_EACC: begin
        eidx_nxt = eidx_r + 1'b1;
        state_nxt = ST_EADDR;
      end
      ST_SUMRD: begin
        if (idx_r == nodes_r) begin
          done_nxt = 1'b1;
        end else begin
          state_nxt = ST_SUMACC;
        end
        // Hand the result over once the output register is free.
        if (done_r && out_free) begin
          done_nxt = 1'b0;
          edge_total_nxt = '0;
          dropped_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      ST_SUMACC: begin
        acc_nxt = sum;
        idx_nxt = idx_r + 1'b1;
        state_nxt = ST_SUMRD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r <= 1'b0;
      edge_total_r <= '0;
      dropped_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r <= done_nxt;
      edge_total_r <= edge_total_nxt;
      dropped_r <= dropped_nxt;
      if (state_r == ST_SUMRD && done_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    nodes_r <= nodes_nxt;
    idx_r <= idx_nxt;
    eidx_r <= eidx_nxt;
    round_r <= round_nxt;
    src_r <= src_nxt;
    tail_r <= tail_nxt;
    acc_r <= acc_nxt;
    if (state_r == ST_SUMRD && done_r && out_free) begin
      out_data_r.path_count <= acc_r;
      out_data_r.overflow <= dropped_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

// File: sv/ldpc_cnt_ram.sv
// One bank of per-node path counts with a registered read port.
// Depends on ldpc_pkg for the count width.
module ldpc_cnt_ram #(
  parameter int DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [$clog2(DEPTH)-1:0]          waddr,
  input  logic [ldpc_pkg::COUNT_W-1:0]      wdata,
  input  logic [$clog2(DEPTH)-1:0]          raddr,
  output logic [ldpc_pkg::COUNT_W-1:0]      rdata
);

  logic [ldpc_pkg::COUNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/ldpc_chk.sv
// Port-level checker for local_dag_path_count_unit, attached with a bind.
// Depends on ldpc_pkg for the channel structs.
module ldpc_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input ldpc_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input ldpc_pkg::out_t out_data
);

  // A held result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A last request always starts a count, during which no request is taken.
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last |=> in_stall)
    else $error("unit not busy after last request");

  // Plain edge requests never make the unit busy.
  a_edge_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_data.last |=> !in_stall)
    else $error("unit busy after an edge request");

  // A new result only appears at the end of a count.
  a_result_after_count: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a count");

endmodule

bind local_dag_path_count_unit ldpc_chk u_ldpc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
